[hdl/sbe_pkg.sv]
// Shared types, opcodes and constants for the stack bytecode executor.
`default_nettype none
package sbe_pkg;

  localparam logic [7:0] OPC_ICONST_M1 = 8'd2;
  localparam logic [7:0] OPC_ICONST_5  = 8'd8;
  localparam logic [7:0] OPC_BIPUSH    = 8'd16;
  localparam logic [7:0] OPC_SIPUSH    = 8'd17;
  localparam logic [7:0] OPC_ILOAD     = 8'd21;
  localparam logic [7:0] OPC_ILOAD_0   = 8'd26;
  localparam logic [7:0] OPC_ILOAD_3   = 8'd29;
  localparam logic [7:0] OPC_ISTORE    = 8'd54;
  localparam logic [7:0] OPC_ISTORE_0  = 8'd59;
  localparam logic [7:0] OPC_ISTORE_3  = 8'd62;
  localparam logic [7:0] OPC_IADD      = 8'd96;
  localparam logic [7:0] OPC_ISUB      = 8'd100;
  localparam logic [7:0] OPC_IMUL      = 8'd104;
  localparam logic [7:0] OPC_IDIV      = 8'd108;
  localparam logic [7:0] OPC_IREM      = 8'd112;
  localparam logic [7:0] OPC_INEG      = 8'd116;
  localparam logic [7:0] OPC_IFEQ      = 8'd159;
  localparam logic [7:0] OPC_IFNE      = 8'd160;
  localparam logic [7:0] OPC_IFLT      = 8'd161;
  localparam logic [7:0] OPC_IFGE      = 8'd162;
  localparam logic [7:0] OPC_IFGT      = 8'd163;
  localparam logic [7:0] OPC_IFLE      = 8'd164;
  localparam logic [7:0] OPC_GOTO      = 8'd167;
  localparam logic [7:0] OPC_IRETURN   = 8'd172;
  localparam logic [7:0] OPC_RETURN    = 8'd177;
  localparam logic [7:0] OPC_HALT      = 8'd255;

  // Instruction class decoded once per item
  typedef enum logic [3:0] {
    K_NOP, K_PUSHK, K_LOAD, K_STORE, K_BIN, K_DIV, K_NEG, K_BR, K_GOTO,
    K_IRET, K_RET, K_START
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP1, S_POP1W, S_POP2, S_POP2W, S_LOCW, S_DIVW, S_EXEC,
    S_CLEAR, S_OUT, S_INIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the item
    logic pop;       // issue stack read at sp-1, decrement sp
    logic take_b;    // latch stack read into b
    logic take_a;    // latch stack read into a
    logic loc_rd;    // issue local read
    logic take_loc;  // latch local read into b
    logic div_go;    // start divider
    logic exec;      // perform write-back and form the result
    logic clr_step;  // clear one local
    logic clr_start; // reset clear index, sp
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  div_done;
    logic  clr_last;
  } sts_t;

endpackage
`default_nettype wire

[hdl/sbe_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/sbe_div.sv]
// Iterative signed divider, one quotient bit per cycle.
`default_nettype none
module sbe_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quot,
  output logic [31:0]      rem
);
  logic [31:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, nq_r, nq_nxt, nr_r, nr_nxt;
  logic [32:0] trial;

  assign trial = {r_r, q_r[31]} - {1'b0, d_r};

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; nq_nxt = nq_r; nr_nxt = nr_r;
    if (start) begin
      q_nxt    = dividend[31] ? 32'd0 - dividend : dividend;
      d_nxt    = divisor[31] ? 32'd0 - divisor : divisor;
      r_nxt    = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
      nq_nxt   = dividend[31] ^ divisor[31];
      nr_nxt   = dividend[31];
    end else if (busy_r) begin
      // Shift in one bit, subtract if it fits
      if (!trial[32]) begin
        r_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = {r_r[30:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; nq_r <= nq_nxt; nr_r <= nr_nxt;
  end

  assign done = !busy_r && !start;
  assign quot = (d_r == 32'd0) ? 32'd0 : (nq_r ? 32'd0 - q_r : q_r);
  assign rem  = (d_r == 32'd0) ? 32'd0 : (nr_r ? 32'd0 - r_r : r_r);
endmodule
`default_nettype wire

[hdl/sbe_datapath.sv]
// Datapath: item registers, stack and locals memories, ALU, result register.
`default_nettype none
module sbe_datapath
  import sbe_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int LOCAL_COUNT = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               in_operation,
  input  wire logic [10:0]        in_instr_address,
  input  wire logic [7:0]         in_opcode,
  input  wire logic signed [8:0]  in_operand_high,
  input  wire logic signed [8:0]  in_operand_low,
  output logic signed [16:0]      out_next_address,
  output logic                    out_finished,
  output logic signed [31:0]      out_return_value,
  output logic [10:0]             out_stack_depth
);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int LAW = $clog2(LOCAL_COUNT);

  logic [10:0]       addr_r;
  logic [7:0]        opc_r;
  logic signed [8:0] hi_r, lo_r;
  kind_t             kind_r, kind_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  logic [31:0]       a_r, b_r, prod_r;
  logic              pv_r;      // the pending stack read is from a real entry
  logic [LAW-1:0]    clr_r;
  logic [31:0]       st_rdata, lc_rdata, quot, rem, wval;
  logic              div_done, st_we, lc_we, push_ok, take;
  logic [SAW-1:0]    st_raddr;
  logic [LAW-1:0]    lc_idx, lc_waddr;
  logic              lc_inrange, lc_ok_r;
  logic signed [16:0] comb16, nxt;

  // Decode opcode class
  always_comb begin
    kind_nxt = K_NOP;
    if (in_operation) kind_nxt = K_START;
    else if (in_opcode inside {[OPC_ICONST_M1:OPC_ICONST_5], OPC_BIPUSH, OPC_SIPUSH})
      kind_nxt = K_PUSHK;
    else if (in_opcode inside {OPC_ILOAD, [OPC_ILOAD_0:OPC_ILOAD_3]}) kind_nxt = K_LOAD;
    else if (in_opcode inside {OPC_ISTORE, [OPC_ISTORE_0:OPC_ISTORE_3]}) kind_nxt = K_STORE;
    else if (in_opcode inside {OPC_IADD, OPC_ISUB, OPC_IMUL}) kind_nxt = K_BIN;
    else if (in_opcode inside {OPC_IDIV, OPC_IREM}) kind_nxt = K_DIV;
    else if (in_opcode == OPC_INEG) kind_nxt = K_NEG;
    else if (in_opcode inside {[OPC_IFEQ:OPC_IFLE]}) kind_nxt = K_BR;
    else if (in_opcode == OPC_GOTO) kind_nxt = K_GOTO;
    else if (in_opcode inside {OPC_IRETURN, OPC_HALT}) kind_nxt = K_IRET;
    else if (in_opcode == OPC_RETURN) kind_nxt = K_RET;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= in_instr_address; opc_r <= in_opcode;
      hi_r <= in_operand_high; lo_r <= in_operand_low;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) kind_r <= K_NOP;
    else if (cmd.capture) kind_r <= kind_nxt;
  end

  // Local index: explicit operand or encoded in opcode
  logic signed [8:0] lidx;
  always_comb begin
    if (opc_r == OPC_ILOAD || opc_r == OPC_ISTORE) lidx = hi_r;
    else if (kind_r == K_LOAD) lidx = 9'(opc_r - OPC_ILOAD_0);
    else lidx = 9'(opc_r - OPC_ISTORE_0);
  end
  assign lc_inrange = !lidx[8] && (int'(lidx) < LOCAL_COUNT);
  assign lc_idx     = LAW'(lidx);

  // Stack pointer and pops
  assign st_raddr = SAW'(sp_r - SPW'(1));
  always_comb begin
    sp_nxt = sp_r;
    if (cmd.clr_start) sp_nxt = '0;
    else if (cmd.pop && sp_r != '0) sp_nxt = sp_r - SPW'(1);
    else if (st_we) sp_nxt = sp_r + SPW'(1);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) sp_r <= '0;
    else sp_r <= sp_nxt;
  end
  always_ff @(posedge clk) begin
    if (cmd.pop) pv_r <= (sp_r != '0);
    if (cmd.take_b) b_r <= pv_r ? st_rdata : 32'd0;
    else if (cmd.take_loc) b_r <= lc_ok_r ? lc_rdata : 32'd0;
    if (cmd.take_a) a_r <= pv_r ? st_rdata : 32'd0;
    if (cmd.loc_rd) lc_ok_r <= lc_inrange;
    prod_r <= a_r * b_r;
  end

  sbe_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_go), .dividend(a_r), .divisor(b_r),
    .done(div_done), .quot(quot), .rem(rem)
  );

  // Value to push
  assign comb16 = 17'(hi_r) * 17'sd256 + 17'(lo_r);
  always_comb begin
    wval = 32'd0;
    case (kind_r)
      K_PUSHK: begin
        if (opc_r == OPC_BIPUSH) wval = 32'(hi_r);
        else if (opc_r == OPC_SIPUSH) wval = 32'(comb16);
        else wval = 32'(opc_r) - 32'd3;
      end
      K_LOAD:  wval = b_r;
      K_BIN: begin
        if (opc_r == OPC_IADD) wval = a_r + b_r;
        else if (opc_r == OPC_ISUB) wval = a_r - b_r;
        else wval = prod_r;
      end
      K_DIV:   wval = (opc_r == OPC_IREM) ? rem : quot;
      K_NEG:   wval = 32'd0 - b_r;
      default: wval = 32'd0;
    endcase
  end
  assign push_ok = sp_r < SPW'(STACK_DEPTH);
  assign st_we = cmd.exec && push_ok &&
                 (kind_r == K_PUSHK || kind_r == K_LOAD || kind_r == K_BIN ||
                  kind_r == K_DIV || kind_r == K_NEG);

  sbe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(SAW'(sp_r)), .wdata(wval),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // Locals: write on store, or zero during clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_start) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + LAW'(1);
  end
  assign lc_we    = cmd.clr_step || (cmd.exec && kind_r == K_STORE && lc_inrange);
  assign lc_waddr = cmd.clr_step ? clr_r : lc_idx;
  sbe_ram #(.WIDTH(32), .DEPTH(LOCAL_COUNT)) u_locals (
    .clk(clk), .we(lc_we), .waddr(lc_waddr), .wdata(cmd.clr_step ? 32'd0 : b_r),
    .raddr(lc_idx), .rdata(lc_rdata)
  );

  // Branch decision
  always_comb begin
    case (opc_r)
      OPC_IFEQ: take = (a_r == b_r);
      OPC_IFNE: take = (a_r != b_r);
      OPC_IFLT: take = $signed(a_r) < $signed(b_r);
      OPC_IFGE: take = !($signed(a_r) < $signed(b_r));
      OPC_IFGT: take = $signed(b_r) < $signed(a_r);
      default:  take = !($signed(b_r) < $signed(a_r));
    endcase
  end

  // Next address
  always_comb begin
    nxt = 17'(addr_r) + 17'sd1;
    if (opc_r == OPC_BIPUSH || opc_r == OPC_ILOAD || opc_r == OPC_ISTORE)
      nxt = 17'(addr_r) + 17'sd2;
    else if (opc_r == OPC_SIPUSH) nxt = 17'(addr_r) + 17'sd3;
    if (kind_r == K_BR) nxt = take ? 17'(addr_r) + comb16 : 17'(addr_r) + 17'sd3;
    else if (kind_r == K_GOTO) nxt = 17'(addr_r) + comb16;
    else if (kind_r == K_START) nxt = '0;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_next_address <= nxt;
      out_finished     <= (kind_r == K_IRET || kind_r == K_RET);
      out_return_value <= (kind_r == K_IRET) ? b_r : 32'd0;
      out_stack_depth  <= 11'(sp_nxt);
    end
  end

  assign sts.kind     = kind_r;
  assign sts.div_done = div_done;
  assign sts.clr_last = (clr_r == LAW'(LOCAL_COUNT - 1));

`ifndef ASSERT_OFF
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
  a_no_dual: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_step && cmd.exec)) else $error("clear and execute together");
  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop && sp_r != '0 |=> sp_r == $past(sp_r) - SPW'(1))
    else $error("pop did not decrement");
`endif
endmodule
`default_nettype wire

[hdl/sbe_ctrl.sv]
// Controller: sequences pops, local reads, division, clear sweep and result.
`default_nettype none
module sbe_ctrl
  import sbe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_POP1;
      S_POP1: begin
        case (sts.kind)
          K_START: state_nxt = S_CLEAR;
          K_LOAD:  state_nxt = S_LOCW;
          K_STORE, K_NEG, K_IRET: state_nxt = S_POP1W;
          K_BIN, K_DIV, K_BR: state_nxt = S_POP1W;
          default: state_nxt = S_EXEC;
        endcase
      end
      S_POP1W: state_nxt = (sts.kind inside {K_BIN, K_DIV, K_BR}) ? S_POP2 : S_EXEC;
      S_POP2:  state_nxt = S_POP2W;
      S_POP2W: state_nxt = (sts.kind == K_DIV) ? S_DIVW : S_EXEC;
      S_LOCW:  state_nxt = S_EXEC;
      S_DIVW:  if (sts.div_done) state_nxt = S_EXEC;
      S_CLEAR: if (sts.clr_last) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sweep the locals to zero after reset before taking items
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else state_r <= state_nxt;
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_INIT:  cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      S_POP1: begin
        cmd.pop = (sts.kind inside {K_STORE, K_NEG, K_IRET, K_BIN, K_DIV, K_BR});
        cmd.loc_rd = (sts.kind == K_LOAD);
        cmd.clr_start = (sts.kind == K_START);
      end
      S_POP1W: begin
        cmd.take_b = 1'b1;
        cmd.pop = (sts.kind inside {K_BIN, K_DIV, K_BR});
      end
      S_POP2:  cmd.take_a = 1'b1;
      S_POP2W: cmd.div_go = (sts.kind == K_DIV);
      S_LOCW:  cmd.take_loc = 1'b1;
      S_CLEAR: cmd.clr_step = 1'b1;
      S_EXEC:  cmd.exec = 1'b1;
      S_OUT:   out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid) else $error("result not presented");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVW && sts.div_done |=> cmd.exec) else $error("divider lost");
`endif
endmodule
`default_nettype wire

[hdl/stack_bytecode_executor.sv]
// Top level of the stack bytecode executor.
// Executes one integer stack instruction per item and returns one result item
// (next address, finished flag, return value, stack depth). One item is in
// flight at a time. Constant pushes, goto, return and unknown opcodes pop
// nothing; loads read one local; stores, ineg, ireturn and halt pop one entry;
// add, sub, mul and the compare branches pop two (each stack pop is a
// registered RAM read); idiv and irem pop two and then run the divider (one
// quotient bit per cycle). A start item sweeps the locals memory to zero one
// entry a cycle. A result waits while out_ready stays low. After reset the
// block clears the locals in one pass with in_ready low.
`default_nettype none
module stack_bytecode_executor
  import sbe_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int LOCAL_COUNT = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_operation,
  input  wire logic [10:0]        in_instr_address,
  input  wire logic [7:0]         in_opcode,
  input  wire logic signed [8:0]  in_operand_high,
  input  wire logic signed [8:0]  in_operand_low,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [16:0]      out_next_address,
  output logic                    out_finished,
  output logic signed [31:0]      out_return_value,
  output logic [10:0]             out_stack_depth
);
  cmd_t cmd;
  sts_t sts;

  sbe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  sbe_datapath #(.STACK_DEPTH(STACK_DEPTH), .LOCAL_COUNT(LOCAL_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_instr_address(in_instr_address),
    .in_opcode(in_opcode), .in_operand_high(in_operand_high),
    .in_operand_low(in_operand_low), .out_next_address(out_next_address),
    .out_finished(out_finished), .out_return_value(out_return_value),
    .out_stack_depth(out_stack_depth)
  );
endmodule
`default_nettype wire
